@@ rtl/pktt_pkg.sv @@
// Shared types and constants for the peer key trust table.
// Used by peer_key_trust_table_core; depends on nothing else.
`default_nettype none

package pktt_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int ID_BITS_DEF     = 64;

   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int TRUST_W   = 2;
   localparam int WORD_W    = 64;
   localparam int TIME_W    = 32;
   localparam int COUNT_W   = 32;
   localparam int STORED_W  = 6;
   localparam int KEY_WORDS = 4;

   // Input tdata: peer_id, key_word0..3, now_seconds (352 bits, 44 bytes).
   localparam int REQ_DATA_W = 352;
   localparam int REQ_USER_W = OP_W;
   // Output tdata: trust, key_differs, counts and times, stored_count (105 -> 112 bits).
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USER_W = STATUS_W;

   typedef enum logic [OP_W-1:0] {
      OP_VERIFY   = 3'd0,
      OP_MARK_OK  = 3'd1,
      OP_MARK_BAD = 3'd2,
      OP_FORGET   = 3'd3,
      OP_QUERY    = 3'd4,
      OP_GET      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_MISMATCH  = 2'd3
   } status_type;

   localparam logic [TRUST_W-1:0] TRUST_FIRST    = 2'd0;
   localparam logic [TRUST_W-1:0] TRUST_VERIFIED = 2'd1;
   localparam logic [TRUST_W-1:0] TRUST_REJECTED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_KEY,
      ST_FILL,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [TRUST_W-1:0] trust;
      logic [COUNT_W-1:0] connections;
      logic [TIME_W-1:0]  first_time;
      logic [TIME_W-1:0]  last_time;
   } record_type;

endpackage

`default_nettype wire

@@ rtl/peer_key_trust_table_core.sv @@
// Trust-on-first-use key pinning table, top level.
// Depends on pktt_pkg for types, codes and default parameter values.
`default_nettype none

// Each request item names a peer by ID and carries an operation (in req_tuser), a 256-bit
// key and the current time; exactly one response item comes back per request. The table
// holds TABLE_DEPTH entries in on-chip memories and is searched by a linear scan that reads
// one stored ID per cycle, so the block is busy for one request at a time. A scan stops at
// the first matching entry; every match then reads the four pinned key words back one per
// cycle through the single key memory port. When an unknown peer is pinned as a new entry,
// its key is written one word per cycle. A finished response waits in an output register,
// so the next request can be taken while it is still pending; a request that finishes while
// that register is still full waits in its commit state until it drains. Reset empties the
// table at once.
module peer_key_trust_table_core #(
   parameter int TABLE_DEPTH = pktt_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS     = pktt_pkg::ID_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // [63:0] peer_id, [127:64] key_word0, [191:128] key_word1, [255:192] key_word2,
   // [319:256] key_word3, [351:320] now_seconds
   input  wire  [pktt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] operation
   input  wire  [pktt_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [1:0] trust, [2] key_differs, [34:3] conn_count, [66:35] first_time,
   // [98:67] last_time, [104:99] stored_count, [111:105] zero
   output logic [pktt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [pktt_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int KADR_W = IDX_W + 2;
   localparam int WORD_W = pktt_pkg::WORD_W;
   localparam int TIME_W = pktt_pkg::TIME_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(TABLE_DEPTH);

   // Table storage.
   logic [ID_BITS-1:0]         id_mem  [TABLE_DEPTH];
   logic [WORD_W-1:0]          key_mem [TABLE_DEPTH*4];
   pktt_pkg::record_type       rec_mem [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0]     valid_ff, valid_in;
   logic [CNT_W-1:0]           total_ff, total_in;

   pktt_pkg::state_type        state_ff, state_in;

   // Latched request.
   logic [pktt_pkg::OP_W-1:0]  op_ff;
   logic [ID_BITS-1:0]         id_ff;
   logic [WORD_W-1:0]          key_ff [4];
   logic [TIME_W-1:0]          now_ff;

   // Scan and key sequencing.
   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic                       pend_ff, pend_in;
   logic [IDX_W-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                       hit_ff, hit_in;
   logic [IDX_W-1:0]           slot_ff, slot_in;
   logic                       free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]           free_ff, free_in;
   logic [2:0]                 kw_ff, kw_in;
   logic                       differ_ff, differ_in;

   logic [ID_BITS-1:0]         id_rd_ff;
   logic [WORD_W-1:0]          key_rd_ff;
   pktt_pkg::record_type       rec_rd_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [pktt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pktt_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // Memory write controls.
   logic                       id_we;
   logic                       rec_we;
   logic [IDX_W-1:0]           rec_waddr;
   pktt_pkg::record_type       rec_wdata;
   logic                       key_we;

   logic                       accept;
   logic                       hit_now, free_now, last_cmp, issue, room;
   logic [1:0]                 kw_prev;
   logic [KADR_W-1:0]          key_raddr, key_waddr;

   // Commit-time result fields.
   logic [pktt_pkg::STATUS_W-1:0] o_status;
   logic [pktt_pkg::TRUST_W-1:0]  o_trust;
   logic                          o_differs;
   logic [pktt_pkg::COUNT_W-1:0]  o_conn;
   logic [TIME_W-1:0]             o_first;
   logic [TIME_W-1:0]             o_last;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == pktt_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign kw_prev   = 2'(kw_ff - 3'd1);
   assign key_raddr = {slot_ff, kw_ff[1:0]};
   assign key_waddr = {free_ff, kw_ff[1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pktt_pkg::ST_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      free_ok_ff  <= free_ok_in;
      free_ff     <= free_in;
      kw_ff       <= kw_in;
      differ_ff   <= differ_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (accept) begin
         op_ff     <= req_tuser;
         id_ff     <= req_tdata[ID_BITS-1:0];
         key_ff[0] <= req_tdata[127:64];
         key_ff[1] <= req_tdata[191:128];
         key_ff[2] <= req_tdata[255:192];
         key_ff[3] <= req_tdata[319:256];
         now_ff    <= req_tdata[351:320];
      end
   end

   // Memories: one read and one write port each, read data registered.
   always_ff @(posedge clock) begin
      id_rd_ff <= id_mem[scan_ff[IDX_W-1:0]];
      if (id_we) begin
         id_mem[free_ff] <= id_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[key_raddr];
      if (key_we) begin
         key_mem[key_waddr] <= key_ff[kw_ff[1:0]];
      end
   end

   always_ff @(posedge clock) begin
      rec_rd_ff <= rec_mem[slot_ff];
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
   end

   // Scan compare terms.
   assign hit_now  = pend_ff && valid_ff[cmp_idx_ff] && (id_rd_ff == id_ff);
   assign free_now = pend_ff && !valid_ff[cmp_idx_ff] && !free_ok_ff;
   assign last_cmp = pend_ff && (cmp_idx_ff == LAST_IDX);
   assign issue    = (scan_ff < MAX_CNT) && !hit_now;
   assign room     = (total_ff < MAX_CNT) && free_ok_ff;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      free_ok_in   = free_ok_ff;
      free_in      = free_ff;
      kw_in        = kw_ff;
      differ_in    = differ_ff;
      id_we        = 1'b0;
      key_we       = 1'b0;
      rec_we       = 1'b0;
      rec_waddr    = slot_ff;
      rec_wdata    = rec_rd_ff;
      o_status     = pktt_pkg::STATUS_OK;
      o_trust      = '0;
      o_differs    = 1'b0;
      o_conn       = '0;
      o_first      = '0;
      o_last       = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pktt_pkg::ST_IDLE: begin
            if (accept) begin
               scan_in    = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               differ_in  = 1'b0;
               state_in   = pktt_pkg::ST_SCAN;
            end
         end

         pktt_pkg::ST_SCAN: begin
            if (free_now) begin
               free_ok_in = 1'b1;
               free_in    = cmp_idx_ff;
            end
            if (issue) begin
               pend_in    = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + 1'b1;
            end
            if (hit_now) begin
               hit_in   = 1'b1;
               slot_in  = cmp_idx_ff;
               kw_in    = '0;
               pend_in  = 1'b0;
               state_in = pktt_pkg::ST_KEY;
            end else if (last_cmp) begin
               kw_in   = '0;
               slot_in = '0;
               if (op_ff == pktt_pkg::OP_VERIFY && (total_ff < MAX_CNT) &&
                   (free_ok_ff || free_now)) begin
                  state_in = pktt_pkg::ST_FILL;
               end else begin
                  state_in = pktt_pkg::ST_COMMIT;
               end
            end
         end

         pktt_pkg::ST_KEY: begin
            // Word kw is read this cycle while word kw-1 is compared.
            if (kw_ff != 3'd0 && key_rd_ff != key_ff[kw_prev]) begin
               differ_in = 1'b1;
            end
            kw_in = kw_ff + 3'd1;
            if (kw_ff == 3'd4) begin
               state_in = pktt_pkg::ST_COMMIT;
            end
         end

         pktt_pkg::ST_FILL: begin
            key_we = 1'b1;
            kw_in  = kw_ff + 3'd1;
            if (kw_ff == 3'd3) begin
               state_in = pktt_pkg::ST_COMMIT;
            end
         end

         pktt_pkg::ST_COMMIT: begin
            if (op_ff > pktt_pkg::OP_GET) begin
               o_status = pktt_pkg::STATUS_OK;
            end else if (op_ff == pktt_pkg::OP_VERIFY) begin
               if (!hit_ff) begin
                  if (!room) begin
                     o_status = pktt_pkg::STATUS_FULL;
                  end else begin
                     rec_we                = 1'b1;
                     rec_waddr             = free_ff;
                     rec_wdata.trust       = pktt_pkg::TRUST_FIRST;
                     rec_wdata.connections = 32'd1;
                     rec_wdata.first_time  = now_ff;
                     rec_wdata.last_time   = now_ff;
                     id_we                 = 1'b1;
                     valid_in[free_ff]     = 1'b1;
                     total_in              = total_ff + 1'b1;
                     o_trust               = pktt_pkg::TRUST_FIRST;
                     o_conn                = 32'd1;
                     o_first               = now_ff;
                     o_last                = now_ff;
                  end
               end else if (differ_ff) begin
                  o_status = pktt_pkg::STATUS_MISMATCH;
                  o_trust  = pktt_pkg::TRUST_REJECTED;
                  o_conn   = rec_rd_ff.connections;
                  o_first  = rec_rd_ff.first_time;
                  o_last   = rec_rd_ff.last_time;
               end else begin
                  rec_we                = 1'b1;
                  rec_wdata.connections = rec_rd_ff.connections + 32'd1;
                  rec_wdata.last_time   = now_ff;
                  o_trust               = rec_rd_ff.trust;
                  o_conn                = rec_wdata.connections;
                  o_first               = rec_rd_ff.first_time;
                  o_last                = now_ff;
               end
            end else if (op_ff == pktt_pkg::OP_QUERY) begin
               if (hit_ff) begin
                  o_trust   = rec_rd_ff.trust;
                  o_differs = differ_ff;
                  o_conn    = rec_rd_ff.connections;
                  o_first   = rec_rd_ff.first_time;
                  o_last    = rec_rd_ff.last_time;
               end
            end else if (!hit_ff) begin
               o_status = pktt_pkg::STATUS_NOT_FOUND;
            end else begin
               if (op_ff == pktt_pkg::OP_MARK_OK) begin
                  rec_we          = 1'b1;
                  rec_wdata.trust = pktt_pkg::TRUST_VERIFIED;
               end else if (op_ff == pktt_pkg::OP_MARK_BAD) begin
                  rec_we          = 1'b1;
                  rec_wdata.trust = pktt_pkg::TRUST_REJECTED;
               end else if (op_ff == pktt_pkg::OP_FORGET) begin
                  valid_in[slot_ff] = 1'b0;
                  if (total_ff != '0) begin
                     total_in = total_ff - 1'b1;
                  end
               end
               o_trust = rec_wdata.trust;
               o_conn  = rec_rd_ff.connections;
               o_first = rec_rd_ff.first_time;
               o_last  = rec_rd_ff.last_time;
            end

            // The table only changes once the response register has room.
            if (rsp_valid_ff && !rsp_tready) begin
               id_we    = 1'b0;
               rec_we   = 1'b0;
               valid_in = valid_ff;
               total_in = total_ff;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = o_status;
               rsp_data_in  = {7'd0, (pktt_pkg::STORED_W)'(total_in), o_last, o_first,
                               o_conn, o_differs, o_trust};
               state_in     = pktt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pktt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
